FILE: hw/rtl/led_matrix_row_scan_shifter_defines.svh
// ----------------------------------------------------------------------------
// LED matrix row scan shifter: assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_ROW_SCAN_SHIFTER_DEFINES_SVH
`define LED_MATRIX_ROW_SCAN_SHIFTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LMRS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lmrs: assertion failed");

// next-cycle implication, disabled during reset
`define LMRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lmrs: assertion failed");

`endif

FILE: hw/rtl/lmrs_pkg.sv
// ----------------------------------------------------------------------------
// lmrs_pkg
// Item types and command codes for the LED matrix row scan shifter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lmrs_pkg;

	localparam int unsigned COL_BITS_W = 7;
	localparam int unsigned INDEX_W    = 5;
	localparam int unsigned LINE_W     = 3;
	localparam int unsigned DRIVE_W    = 7;

	typedef enum logic [1:0] {
		CMD_TICK         = 2'd0,
		CMD_ROW_START    = 2'd1,
		CMD_COLUMN_WRITE = 2'd2,
		CMD_UNUSED       = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]            cmd;
		logic [INDEX_W-1:0]    column_index;
		logic [COL_BITS_W-1:0] column_bits;
	} in_item_t;

	typedef struct packed {
		logic               shift_clock;
		logic               shift_data;
		logic               latch_line;
		logic [DRIVE_W-1:0] row_drive;
		logic               frame_end;
		logic               ticking;
	} out_item_t;

	// column store write request
	typedef struct packed {
		logic                  en;
		logic [INDEX_W-1:0]    index;
		logic [COL_BITS_W-1:0] bits;
	} store_wr_t;

endpackage

`default_nettype wire

FILE: hw/rtl/led_matrix_row_scan_shifter.sv
// Path: an accepted item passes the input stage and then the result register before it shows
// on result_valid; a result-side stall can hold it between the two.
// Throughput: one item per cycle unless the result stalls; sequencer state and column store
// update in one pass. Stalls on the result side back up through the input stage only.
// Reset (arst_n low, asynchronous): store cleared, counters 0, last row selected,
// running, pins clock 0 / data 0 / latch 1, no items held.
// ----------------------------------------------------------------------------
// led_matrix_row_scan_shifter
// Row-scan serial shift driver for a column-stored LED dot matrix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module led_matrix_row_scan_shifter #(
	parameter int unsigned MATRIX_COLUMNS = 20,
	parameter int unsigned MATRIX_ROWS    = 7
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  item_valid,
	output logic                 item_ready,
	input  lmrs_pkg::in_item_t   item,
	output logic                 result_valid,
	input  wire                  result_ready,
	output lmrs_pkg::out_item_t  result
);

	lmrs_pkg::in_item_t                 item_s1;
	logic                               valid_s1;
	logic                               advance;
	lmrs_pkg::store_wr_t                wr;
	logic [$clog2(MATRIX_COLUMNS)-1:0]  rd_col;
	logic [lmrs_pkg::COL_BITS_W-1:0]    rd_bits;
	lmrs_pkg::out_item_t                res;
	lmrs_pkg::out_item_t                result_q;
	logic                               result_valid_q;

	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	lmrs_col_store #(
		.MATRIX_COLUMNS(MATRIX_COLUMNS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_col  (rd_col),
		.rd_bits (rd_bits)
	);

	lmrs_scan_ctrl #(
		.MATRIX_COLUMNS(MATRIX_COLUMNS),
		.MATRIX_ROWS   (MATRIX_ROWS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.item    (item_s1),
		.rd_bits (rd_bits),
		.rd_col  (rd_col),
		.wr      (wr),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

FILE: hw/rtl/lmrs_col_store.sv
// ----------------------------------------------------------------------------
// lmrs_col_store
// Column pixel store: one write port, one read port at the scan column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmrs_col_store #(
	parameter int unsigned MATRIX_COLUMNS = 20
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  lmrs_pkg::store_wr_t                  wr,
	input  wire  [$clog2(MATRIX_COLUMNS)-1:0]    rd_col,
	output logic [lmrs_pkg::COL_BITS_W-1:0]      rd_bits
);

	logic [lmrs_pkg::COL_BITS_W-1:0] col_q [MATRIX_COLUMNS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MATRIX_COLUMNS; i++) begin
				col_q[i] <= '0;
			end
		end else if (wr.en) begin
			// out-of-range index matches no entry and is dropped
			for (int i = 0; i < MATRIX_COLUMNS; i++) begin
				if ({2'b00, wr.index} == 7'(i)) begin
					col_q[i] <= wr.bits;
				end
			end
		end
	end

	assign rd_bits = col_q[rd_col];

endmodule

`default_nettype wire

FILE: hw/rtl/lmrs_scan_ctrl.sv
// ----------------------------------------------------------------------------
// lmrs_scan_ctrl
// Scan sequencer: column/line counters, clock phase, latch and row select.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmrs_scan_ctrl #(
	parameter int unsigned MATRIX_COLUMNS = 20,
	parameter int unsigned MATRIX_ROWS    = 7
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  fire,
	input  lmrs_pkg::in_item_t                   item,
	input  wire  [lmrs_pkg::COL_BITS_W-1:0]      rd_bits,
	output logic [$clog2(MATRIX_COLUMNS)-1:0]    rd_col,
	output lmrs_pkg::store_wr_t                  wr,
	output lmrs_pkg::out_item_t                  res
);

	localparam int unsigned COL_W = $clog2(MATRIX_COLUMNS);
	localparam int unsigned ROW_W = $clog2(MATRIX_ROWS + 1);

	logic [COL_W-1:0]            col_q,   col_d;
	logic [lmrs_pkg::LINE_W-1:0] line_q,  line_d;
	logic [ROW_W-1:0]            row_q,   row_d;
	logic                        phase_q, phase_d;
	logic                        lpend_q, lpend_d;
	logic                        run_q,   run_d;
	logic                        clk_q,   clk_d;
	logic                        data_q,  data_d;
	logic                        latch_q, latch_d;
	logic                        frame;
	logic                        pixel;

	assign rd_col = col_q;
	// bit 7 of the line lies beyond the stored column and reads as 0
	assign pixel = (line_q < 3'(lmrs_pkg::COL_BITS_W)) ? rd_bits[line_q] : 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			line_q  <= '0;
			row_q   <= ROW_W'(MATRIX_ROWS);
			phase_q <= 1'b0;
			lpend_q <= 1'b0;
			run_q   <= 1'b1;
			clk_q   <= 1'b0;
			data_q  <= 1'b0;
			latch_q <= 1'b1;
		end else if (fire) begin
			col_q   <= col_d;
			line_q  <= line_d;
			row_q   <= row_d;
			phase_q <= phase_d;
			lpend_q <= lpend_d;
			run_q   <= run_d;
			clk_q   <= clk_d;
			data_q  <= data_d;
			latch_q <= latch_d;
		end
	end

	always_comb begin
		col_d    = col_q;
		line_d   = line_q;
		row_d    = row_q;
		phase_d  = phase_q;
		lpend_d  = lpend_q;
		run_d    = run_q;
		clk_d    = clk_q;
		data_d   = data_q;
		latch_d  = latch_q;
		frame    = 1'b0;
		wr.en    = 1'b0;
		wr.index = item.column_index;
		wr.bits  = item.column_bits;

		case (lmrs_pkg::cmd_t'(item.cmd))
			lmrs_pkg::CMD_TICK: begin
				if (run_q) begin
					if (lpend_q) begin
						// latch tick: stop, raise latch, next row and line (line 0 at frame end)
						run_d   = 1'b0;
						lpend_d = 1'b0;
						latch_d = 1'b1;
						if (row_q != '0) begin
							if (row_q >= ROW_W'(MATRIX_ROWS)) begin
								row_d = ROW_W'(1);
							end else begin
								row_d = row_q + ROW_W'(1);
							end
							frame = (row_d == ROW_W'(MATRIX_ROWS));
						end
						line_d = frame ? '0 : line_q + 3'd1;
					end else if (phase_q) begin
						data_d  = pixel;
						clk_d   = 1'b0;
						phase_d = 1'b0;
					end else begin
						clk_d   = 1'b1;
						phase_d = 1'b1;
						if (col_q >= COL_W'(MATRIX_COLUMNS - 1)) begin
							col_d   = '0;
							latch_d = 1'b0;
							lpend_d = 1'b1;
						end else begin
							col_d = col_q + COL_W'(1);
						end
					end
				end
			end
			lmrs_pkg::CMD_ROW_START: begin
				run_d = 1'b1;
			end
			lmrs_pkg::CMD_COLUMN_WRITE: begin
				wr.en = fire && ({2'b00, item.column_index} < 7'(MATRIX_COLUMNS));
			end
			default: begin
			end
		endcase

		res.shift_clock = clk_d;
		res.shift_data  = data_d;
		res.latch_line  = latch_d;
		for (int k = 0; k < lmrs_pkg::DRIVE_W; k++) begin
			res.row_drive[k] = (4'(row_d) == 4'(k + 1));
		end
		res.frame_end = frame;
		res.ticking   = run_d;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/lmrs_checker.sv
// ----------------------------------------------------------------------------
// lmrs_checker
// Port-level checks on the result channel of the row scan shifter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "led_matrix_row_scan_shifter_defines.svh"

module lmrs_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  result_valid,
	input wire                  result_ready,
	input lmrs_pkg::out_item_t  result
);

	// at most one row enabled
	`LMRS_ASSERT_IMPL(a_row_onehot, result_valid, $onehot0(result.row_drive))

	// a frame end only comes from a latch tick, which stops the run
	`LMRS_ASSERT_IMPL(a_frame_stops, result_valid && result.frame_end, !result.ticking)

	// latch goes low only right after the rising edge of the last column
	`LMRS_ASSERT_IMPL(a_latch_clk_high, result_valid && !result.latch_line, result.shift_clock)

	// a stalled item holds
	`LMRS_ASSERT_NEXT(a_stall_hold, result_valid && !result_ready, result_valid && $stable(result))

endmodule

bind led_matrix_row_scan_shifter lmrs_checker u_lmrs_checker (.*);

`default_nettype wire

FILE: tb/sv/led_matrix_row_scan_shifter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_row_scan_shifter_tb
// Self-checking bench for the row scan shifter. A directed table covers
// reset pins, ignored writes and commands, a whole line up to the latch and
// the stop/resume behaviour. Random ticks and row starts with writes and
// stray commands mixed in then follow. Each result is checked against the
// table or an in-bench sequencer model. Both handshakes idle at random.
// ----------------------------------------------------------------------------

module led_matrix_row_scan_shifter_tb;

	localparam int N_COLS         = 20;
	localparam int N_ROWS         = 7;
	localparam int RAND_ITEMS     = 400;
	localparam int TIMEOUT_CYCLES = 400000;
	localparam int MAX_SHOWN      = 10;
	localparam int DRAIN_CYCLES   = 10;

	typedef struct packed {
		lmrs_pkg::cmd_t      cmd;
		logic [4:0]          idx;
		logic [6:0]          bits;
		logic [7:0]          reps;
		logic                typed;
		lmrs_pkg::out_item_t want;
	} dir_row_t;

	// pins straight out of reset: last row selected, running
	localparam lmrs_pkg::out_item_t AFTER_RESET = '{1'b0, 1'b0, 1'b1, 7'h40, 1'b0, 1'b1};
	localparam lmrs_pkg::out_item_t FIRST_RISE  = '{1'b1, 1'b0, 1'b1, 7'h40, 1'b0, 1'b1};
	localparam lmrs_pkg::out_item_t FIRST_FALL  = '{1'b0, 1'b1, 1'b1, 7'h40, 1'b0, 1'b1};
	localparam lmrs_pkg::out_item_t LAST_RISE   = '{1'b1, 1'b0, 1'b0, 7'h40, 1'b0, 1'b1};
	localparam lmrs_pkg::out_item_t STOPPED_R1  = '{1'b1, 1'b0, 1'b1, 7'h01, 1'b0, 1'b0};
	localparam lmrs_pkg::out_item_t RESUMED_R1  = '{1'b1, 1'b0, 1'b1, 7'h01, 1'b0, 1'b1};
	localparam lmrs_pkg::out_item_t NO_CHECK    = '0;
	localparam int                  DIR_LEN     = 20;

	localparam dir_row_t DIR_TAB [DIR_LEN] = '{
		'{lmrs_pkg::CMD_COLUMN_WRITE, 5'd0,  7'h7f, 8'd1,  1'b1, AFTER_RESET},
		'{lmrs_pkg::CMD_COLUMN_WRITE, 5'd19, 7'h00, 8'd1,  1'b1, AFTER_RESET},
		'{lmrs_pkg::CMD_COLUMN_WRITE, 5'd31, 7'h55, 8'd1,  1'b1, AFTER_RESET},  // index out of range
		'{lmrs_pkg::CMD_COLUMN_WRITE, 5'd20, 7'h2a, 8'd1,  1'b1, AFTER_RESET},
		'{lmrs_pkg::CMD_UNUSED,       5'd5,  7'h7f, 8'd1,  1'b1, AFTER_RESET},
		'{lmrs_pkg::CMD_COLUMN_WRITE, 5'd1,  7'h01, 8'd1,  1'b0, NO_CHECK},
		'{lmrs_pkg::CMD_COLUMN_WRITE, 5'd2,  7'h40, 8'd1,  1'b0, NO_CHECK},
		'{lmrs_pkg::CMD_TICK,         5'd31, 7'h7f, 8'd1,  1'b1, FIRST_RISE},
		'{lmrs_pkg::CMD_TICK,         5'd0,  7'h00, 8'd1,  1'b1, FIRST_FALL},
		'{lmrs_pkg::CMD_ROW_START,    5'd31, 7'h7f, 8'd1,  1'b0, NO_CHECK},
		// walk the rest of the line up to the last rising edge
		'{lmrs_pkg::CMD_TICK,         5'd0,  7'h00, 8'd36, 1'b0, NO_CHECK},
		'{lmrs_pkg::CMD_TICK,         5'd0,  7'h00, 8'd1,  1'b1, LAST_RISE},
		'{lmrs_pkg::CMD_TICK,         5'd0,  7'h00, 8'd1,  1'b1, STOPPED_R1},
		'{lmrs_pkg::CMD_TICK,         5'd31, 7'h7f, 8'd1,  1'b1, STOPPED_R1},   // tick while stopped
		'{lmrs_pkg::CMD_UNUSED,       5'd0,  7'h00, 8'd1,  1'b1, STOPPED_R1},
		'{lmrs_pkg::CMD_ROW_START,    5'd0,  7'h00, 8'd1,  1'b1, RESUMED_R1},
		'{lmrs_pkg::CMD_TICK,         5'd0,  7'h00, 8'd1,  1'b0, NO_CHECK},
		'{lmrs_pkg::CMD_COLUMN_WRITE, 5'd0,  7'h00, 8'd1,  1'b0, NO_CHECK},
		'{lmrs_pkg::CMD_TICK,         5'd0,  7'h00, 8'd1,  1'b0, NO_CHECK},
		'{lmrs_pkg::CMD_TICK,         5'd0,  7'h00, 8'd1,  1'b0, NO_CHECK}
	};

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                result_ready = 1'b0;
	lmrs_pkg::in_item_t  item         = '0;
	logic                item_ready;
	logic                result_valid;
	lmrs_pkg::out_item_t result;

	led_matrix_row_scan_shifter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// scan sequencer model state
	logic [6:0] col_mem [N_COLS];
	logic [4:0] col_cnt;
	logic [2:0] line_cnt;
	logic       clk_phase;
	logic       latch_due;
	logic [2:0] row_sel;
	logic       scan_on;
	logic       pin_clk, pin_dat, pin_lat;

	lmrs_pkg::out_item_t pin_expect_q [$];
	int          burst_left = 0;
	int          mism_cnt   = 0;
	int          cycle_cnt  = 0;
	logic [15:0] ready_pat  = 16'hffff;
	int          pat_left   = 0;

	function automatic lmrs_pkg::out_item_t scan_step(lmrs_pkg::in_item_t it);
		lmrs_pkg::out_item_t o;
		logic                fe;
		fe = 1'b0;
		case (lmrs_pkg::cmd_t'(it.cmd))
			lmrs_pkg::CMD_TICK: begin
				if (scan_on) begin
					if (latch_due) begin
						scan_on   = 1'b0;
						latch_due = 1'b0;
						pin_lat   = 1'b1;
						// no row selected: select stays, no frame
						if (row_sel != 3'd0) begin
							row_sel = (row_sel >= N_ROWS) ? 3'd1 : 3'(row_sel + 3'd1);
							fe = (row_sel == N_ROWS);
						end
						line_cnt = fe ? 3'd0 : 3'(line_cnt + 3'd1);
					end else if (clk_phase) begin
						// row 8 lies beyond the stored bits and reads as 0
						pin_dat = (col_cnt < N_COLS && line_cnt < 3'd7) ?
							col_mem[col_cnt][line_cnt] : 1'b0;
						pin_clk   = 1'b0;
						clk_phase = 1'b0;
					end else begin
						pin_clk   = 1'b1;
						clk_phase = 1'b1;
						if (col_cnt >= N_COLS - 1) begin
							col_cnt   = 5'd0;
							pin_lat   = 1'b0;
							latch_due = 1'b1;
						end else begin
							col_cnt = 5'(col_cnt + 5'd1);
						end
					end
				end
			end
			lmrs_pkg::CMD_ROW_START: scan_on = 1'b1;
			lmrs_pkg::CMD_COLUMN_WRITE: begin
				if (it.column_index < N_COLS)
					col_mem[it.column_index] = it.column_bits;
			end
			default: ;
		endcase
		o.shift_clock = pin_clk;
		o.shift_data  = pin_dat;
		o.latch_line  = pin_lat;
		o.row_drive   = (row_sel != 3'd0) ? 7'(7'd1 << (row_sel - 3'd1)) : 7'd0;
		o.frame_end   = fe;
		o.ticking     = scan_on;
		return o;
	endfunction

	function automatic string pins_str(lmrs_pkg::out_item_t o);
		return $sformatf("clk %0b data %0b latch %0b rows %02h frame %0b ticking %0b",
			o.shift_clock, o.shift_data, o.latch_line, o.row_drive, o.frame_end, o.ticking);
	endfunction

	// hand one item over; bursts of random length, random gaps in between
	task automatic send_item(lmrs_pkg::in_item_t it, logic typed, lmrs_pkg::out_item_t want);
		int                  gap;
		lmrs_pkg::out_item_t exp_pins;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		exp_pins = scan_step(it);
		pin_expect_q.push_back(typed ? want : exp_pins);
	endtask

	// receiver stalls on a rotating pattern, reshuffled now and then
	always @(posedge clk) begin
		if (pat_left == 0) begin
			ready_pat = ($urandom_range(0, 3) == 0) ? 16'hffff :
				16'($urandom | $urandom) | 16'h0001;
			pat_left  = $urandom_range(16, 96);
		end
		result_ready <= ready_pat[0];
		ready_pat = {ready_pat[0], ready_pat[15:1]};
		pat_left--;
	end

	always @(posedge clk) begin
		lmrs_pkg::out_item_t want;
		cycle_cnt++;
		if (cycle_cnt > TIMEOUT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
		if (arst_n && result_valid && result_ready) begin
			if (pin_expect_q.size() == 0) begin
				mism_cnt++;
				if (mism_cnt <= MAX_SHOWN)
					$display("unexpected result: %s", pins_str(result));
			end else begin
				want = pin_expect_q.pop_front();
				if (result.shift_clock !== want.shift_clock ||
						result.shift_data !== want.shift_data ||
						result.latch_line !== want.latch_line ||
						result.row_drive !== want.row_drive ||
						result.frame_end !== want.frame_end ||
						result.ticking !== want.ticking) begin
					mism_cnt++;
					if (mism_cnt <= MAX_SHOWN)
						$display("mismatch at cycle %0d: expected %s, got %s",
							cycle_cnt, pins_str(want), pins_str(result));
				end
			end
		end
	end

	initial begin
		lmrs_pkg::in_item_t it;
		int                 sel;

		for (int i = 0; i < N_COLS; i++)
			col_mem[i] = 7'd0;
		col_cnt   = 5'd0;
		line_cnt  = 3'd0;
		clk_phase = 1'b0;
		latch_due = 1'b0;
		row_sel   = 3'(N_ROWS);
		scan_on   = 1'b1;
		pin_clk   = 1'b0;
		pin_dat   = 1'b0;
		pin_lat   = 1'b1;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_LEN; r++) begin
			it.cmd          = DIR_TAB[r].cmd;
			it.column_index = DIR_TAB[r].idx;
			it.column_bits  = DIR_TAB[r].bits;
			repeat (DIR_TAB[r].reps)
				send_item(it, DIR_TAB[r].typed, DIR_TAB[r].want);
		end

		// mostly ticks while running and row starts while stopped; writes and stray commands mixed in
		for (int n = 0; n < RAND_ITEMS; n++) begin
			it.column_index = 5'($urandom);
			it.column_bits  = 7'($urandom);
			sel = $urandom_range(0, 99);
			if (!scan_on)
				it.cmd = (sel < 70) ? lmrs_pkg::CMD_ROW_START :
					(sel < 85) ? lmrs_pkg::CMD_TICK :
					(sel < 95) ? lmrs_pkg::CMD_UNUSED : lmrs_pkg::CMD_COLUMN_WRITE;
			else
				it.cmd = (sel < 80) ? lmrs_pkg::CMD_TICK :
					(sel < 92) ? lmrs_pkg::CMD_COLUMN_WRITE :
					(sel < 96) ? lmrs_pkg::CMD_ROW_START : lmrs_pkg::CMD_UNUSED;
			if (it.cmd == lmrs_pkg::CMD_COLUMN_WRITE)
				it.column_index = ($urandom_range(0, 9) == 0) ?
					5'($urandom_range(20, 31)) : 5'($urandom_range(0, 19));
			send_item(it, 1'b0, NO_CHECK);
		end
		item_valid <= 1'b0;

		while (pin_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mism_cnt == 0 && pin_expect_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/lmrs_pkg.sv
hw/rtl/lmrs_col_store.sv
hw/rtl/lmrs_scan_ctrl.sv
hw/rtl/led_matrix_row_scan_shifter.sv
hw/rtl/lmrs_checker.sv
tb/sv/led_matrix_row_scan_shifter_tb.sv
